// ===== sv/cfls_pkg.sv =====
// cfls_pkg: lexer state codes, verdict codes, character constants and the
// step result type for the floating literal scanner
// no dependencies
package cfls_pkg;

  localparam int StateW = 5;
  localparam int VerdictW = 3;

  typedef logic [StateW-1:0]   lex_state_t;
  typedef logic [VerdictW-1:0] verdict_t;
  typedef logic [7:0]          byte_t;

  localparam lex_state_t ST_NORMAL   = 5'd0;
  localparam lex_state_t ST_SLASH    = 5'd1;
  localparam lex_state_t ST_MLCOM    = 5'd2;
  localparam lex_state_t ST_SLCOM    = 5'd3;
  localparam lex_state_t ST_STR      = 5'd4;
  localparam lex_state_t ST_CHR      = 5'd5;
  localparam lex_state_t ST_STR_ESC  = 5'd6;
  localparam lex_state_t ST_CHR_ESC  = 5'd7;
  localparam lex_state_t ST_STAR     = 5'd8;
  localparam lex_state_t ST_IDENT    = 5'd9;
  localparam lex_state_t ST_INT      = 5'd10;
  localparam lex_state_t ST_DOT      = 5'd11;
  localparam lex_state_t ST_FRAC     = 5'd12;
  localparam lex_state_t ST_EXP_MARK = 5'd13;
  localparam lex_state_t ST_EXP      = 5'd14;
  localparam lex_state_t ST_EXP_SIGN = 5'd15;
  localparam lex_state_t ST_LONG     = 5'd16;
  localparam lex_state_t ST_FLOAT    = 5'd17;

  localparam verdict_t V_NONE    = 3'd0;
  localparam verdict_t V_ERROR   = 3'd1;
  localparam verdict_t V_DOUBLE  = 3'd2;
  localparam verdict_t V_LDOUBLE = 3'd3;
  localparam verdict_t V_FLOAT   = 3'd4;

  localparam byte_t CH_DQUOTE = 8'h22;
  localparam byte_t CH_SQUOTE = 8'h27;
  localparam byte_t CH_STAR   = 8'h2A;
  localparam byte_t CH_PLUS   = 8'h2B;
  localparam byte_t CH_MINUS  = 8'h2D;
  localparam byte_t CH_DOT    = 8'h2E;
  localparam byte_t CH_SLASH  = 8'h2F;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_UNDER  = 8'h5F;
  localparam byte_t CH_LF     = 8'h0A;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_UP_E   = 8'h45;
  localparam byte_t CH_LO_E   = 8'h65;
  localparam byte_t CH_UP_L   = 8'h4C;
  localparam byte_t CH_LO_L   = 8'h6C;
  localparam byte_t CH_UP_F   = 8'h46;
  localparam byte_t CH_LO_F   = 8'h66;

  typedef struct packed {
    lex_state_t state;
    logic       echo;
    verdict_t   verdict;
  } step_t;

endpackage

// ===== sv/cfls_next.sv =====
// cfls_next: combinational lexer step, current state and byte to next state,
// echo flag and verdict
// depends on cfls_pkg
module cfls_next (
  input  cfls_pkg::lex_state_t state,
  input  cfls_pkg::byte_t      c,
  output cfls_pkg::step_t      step
);

  logic                 is_letter;
  logic                 is_digit;
  cfls_pkg::lex_state_t after_lit;

  assign is_letter = (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || (c == cfls_pkg::CH_UNDER);
  assign is_digit  = c inside {[8'h30:8'h39]};

  // state after a literal ends on a non-digit byte
  always_comb begin
    if (c == cfls_pkg::CH_DQUOTE) after_lit = cfls_pkg::ST_STR;
    else if (c == cfls_pkg::CH_SQUOTE) after_lit = cfls_pkg::ST_CHR;
    else if (c == cfls_pkg::CH_SLASH) after_lit = cfls_pkg::ST_SLASH;
    else if (is_letter) after_lit = cfls_pkg::ST_IDENT;
    else after_lit = cfls_pkg::ST_NORMAL;
  end

  always_comb begin
    step.state   = state;
    step.echo    = 1'b0;
    step.verdict = cfls_pkg::V_NONE;
    case (state)
      cfls_pkg::ST_STR: begin
        if (c == cfls_pkg::CH_BSLASH) step.state = cfls_pkg::ST_STR_ESC;
        else if (c == cfls_pkg::CH_DQUOTE) step.state = cfls_pkg::ST_NORMAL;
      end
      cfls_pkg::ST_CHR: begin
        if (c == cfls_pkg::CH_BSLASH) step.state = cfls_pkg::ST_CHR_ESC;
        else if (c == cfls_pkg::CH_SQUOTE) step.state = cfls_pkg::ST_NORMAL;
      end
      cfls_pkg::ST_STR_ESC: step.state = cfls_pkg::ST_STR;
      cfls_pkg::ST_CHR_ESC: step.state = cfls_pkg::ST_CHR;
      cfls_pkg::ST_MLCOM: begin
        if (c == cfls_pkg::CH_STAR) step.state = cfls_pkg::ST_STAR;
      end
      cfls_pkg::ST_SLCOM: begin
        if (c == cfls_pkg::CH_LF || c == cfls_pkg::CH_CR) step.state = cfls_pkg::ST_NORMAL;
      end
      cfls_pkg::ST_STAR: begin
        if (c == cfls_pkg::CH_SLASH) step.state = cfls_pkg::ST_NORMAL;
        else if (c != cfls_pkg::CH_STAR) step.state = cfls_pkg::ST_MLCOM;
      end
      cfls_pkg::ST_IDENT: begin
        if (c == cfls_pkg::CH_SLASH) step.state = cfls_pkg::ST_SLASH;
        else if (!is_letter && !is_digit) step.state = cfls_pkg::ST_NORMAL;
      end
      cfls_pkg::ST_INT: begin
        if (c == cfls_pkg::CH_DOT) begin
          step.state = cfls_pkg::ST_FRAC;
          step.echo  = 1'b1;
        end else if (c == cfls_pkg::CH_LO_E) begin
          step.state = cfls_pkg::ST_EXP_MARK;
          step.echo  = 1'b1;
        end else if (is_digit) begin
          step.echo = 1'b1;
        end else begin
          step.state   = after_lit;
          step.verdict = cfls_pkg::V_ERROR;
          step.echo    = !(c == cfls_pkg::CH_DQUOTE || c == cfls_pkg::CH_SQUOTE ||
                           c == cfls_pkg::CH_SLASH);
        end
      end
      cfls_pkg::ST_DOT: begin
        step.echo = 1'b1;
        if (is_digit) begin
          step.state = cfls_pkg::ST_FRAC;
        end else begin
          step.state   = after_lit;
          step.verdict = cfls_pkg::V_ERROR;
        end
      end
      cfls_pkg::ST_FRAC, cfls_pkg::ST_EXP: begin
        if (is_digit) begin
          step.echo = 1'b1;
        end else if (c == cfls_pkg::CH_DOT && state == cfls_pkg::ST_FRAC) begin
          step.state   = cfls_pkg::ST_IDENT;
          step.echo    = 1'b1;
          step.verdict = cfls_pkg::V_ERROR;
        end else if (c == cfls_pkg::CH_UP_L || c == cfls_pkg::CH_LO_L) begin
          step.state = cfls_pkg::ST_LONG;
          step.echo  = 1'b1;
        end else if (c == cfls_pkg::CH_UP_F || c == cfls_pkg::CH_LO_F) begin
          step.state = cfls_pkg::ST_FLOAT;
          step.echo  = 1'b1;
        end else if (c == cfls_pkg::CH_LO_E && state == cfls_pkg::ST_FRAC) begin
          step.state = cfls_pkg::ST_EXP_MARK;
          step.echo  = 1'b1;
        end else if (is_letter) begin
          step.state   = cfls_pkg::ST_IDENT;
          step.echo    = 1'b1;
          step.verdict = cfls_pkg::V_ERROR;
        end else begin
          step.state   = after_lit;
          step.verdict = cfls_pkg::V_DOUBLE;
        end
      end
      cfls_pkg::ST_EXP_MARK: begin
        step.echo = 1'b1;
        if (c == cfls_pkg::CH_PLUS || c == cfls_pkg::CH_MINUS) begin
          step.state = cfls_pkg::ST_EXP_SIGN;
        end else if (is_digit) begin
          step.state = cfls_pkg::ST_EXP;
        end else begin
          step.state   = after_lit;
          step.verdict = cfls_pkg::V_ERROR;
        end
      end
      cfls_pkg::ST_EXP_SIGN: begin
        step.echo = 1'b1;
        if (is_digit) begin
          step.state = cfls_pkg::ST_EXP;
        end else begin
          step.state   = after_lit;
          step.verdict = cfls_pkg::V_ERROR;
        end
      end
      cfls_pkg::ST_LONG, cfls_pkg::ST_FLOAT: begin
        if (is_digit || is_letter) begin
          step.state   = cfls_pkg::ST_IDENT;
          step.echo    = 1'b1;
          step.verdict = cfls_pkg::V_ERROR;
        end else begin
          step.state   = after_lit;
          step.verdict = (state == cfls_pkg::ST_LONG) ? cfls_pkg::V_LDOUBLE
                                                      : cfls_pkg::V_FLOAT;
        end
      end
      default: begin
        // normal, slash and unused codes
        if (c == cfls_pkg::CH_SQUOTE) begin
          step.state = cfls_pkg::ST_CHR;
        end else if (c == cfls_pkg::CH_DQUOTE) begin
          step.state = cfls_pkg::ST_STR;
        end else if (c == cfls_pkg::CH_DOT) begin
          step.state = cfls_pkg::ST_DOT;
          step.echo  = 1'b1;
        end else if (c == cfls_pkg::CH_SLASH) begin
          step.state = (state == cfls_pkg::ST_SLASH) ? cfls_pkg::ST_SLCOM : cfls_pkg::ST_SLASH;
        end else if (c == cfls_pkg::CH_STAR && state == cfls_pkg::ST_SLASH) begin
          step.state = cfls_pkg::ST_MLCOM;
        end else if (is_letter) begin
          step.state = cfls_pkg::ST_IDENT;
        end else if (is_digit) begin
          step.state = cfls_pkg::ST_INT;
          step.echo  = 1'b1;
        end else begin
          step.state = cfls_pkg::ST_NORMAL;
        end
      end
    endcase
  end

endmodule

// ===== sv/c_float_literal_scanner_core.sv =====
// c_float_literal_scanner_core: top level, lexer state register and result register
// depends on cfls_pkg and cfls_next
//
// Scans C source one byte per transfer and takes a new byte every cycle unless
// stalled. Each byte steps an 18-state lexer; a byte that echoes a literal
// character or ends a literal yields one result (echo_valid, echo_char,
// verdict), held in a single result register and valid in the cycle after its
// transfer. Bytes inside strings, comments or identifiers yield no result. The
// input is stalled only while a result waits in that register and out_ready is
// low. Verdicts: 0 none, 1 error, 2 double, 3 long double, 4 float. An
// unfinished literal at the end of the stream gets no verdict.
module c_float_literal_scanner_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       echo_valid,
  output logic [7:0] echo_char,
  output logic [2:0] verdict
);

  cfls_pkg::lex_state_t lex_state;
  cfls_pkg::step_t      step;
  logic                 in_xfer;
  logic                 emit;

  cfls_next u_next (
    .state (lex_state),
    .c     (in_byte),
    .step  (step)
  );

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign emit     = step.echo || (step.verdict != cfls_pkg::V_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state <= cfls_pkg::ST_NORMAL;
      out_valid <= 1'b0;
    end else begin
      if (in_xfer) lex_state <= step.state;
      if (in_xfer) out_valid <= emit;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      echo_valid <= step.echo;
      echo_char  <= step.echo ? in_byte : 8'h00;
      verdict    <= step.verdict;
    end
  end

endmodule

// ===== tb/tb_c_float_literal_scanner_core.sv =====
// tb_c_float_literal_scanner_core: self-checking bench for the float literal scanner,
// a short byte table then random C-like token streams, with bursty input and stalled output
// depends on cfls_pkg and c_float_literal_scanner_core
module tb_c_float_literal_scanner_core;

  typedef struct packed {
    logic               echo;
    cfls_pkg::byte_t    ch;
    cfls_pkg::verdict_t vd;
  } lit_result_t;

  // one source byte; typed rows carry the expected outcome written out by hand
  typedef struct packed {
    cfls_pkg::byte_t ch;
    logic            typed;
    logic            has;
    lit_result_t     res;
  } src_row_t;

  localparam lit_result_t NoRes = '0;
  localparam string Digits = "0123456789";
  localparam string Letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string Alnum = "abcxyzEeLlFf_0123456789";
  localparam string Terms = " ;,)\n/\"'+-*xL0.e";

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic       echo_valid;
  logic [7:0] echo_char;
  logic [2:0] verdict;

  src_row_t             cur_row;
  lit_result_t          exp_lits[$];
  cfls_pkg::lex_state_t scan_state;
  int                   live_items = 0;
  int                   fail_cnt = 0;
  int                   burst_left = 0;
  bit                   hold_req = 1'b0;

  src_row_t directed_text [28] = '{
    '{8'h00,               1'b1, 1'b0, NoRes},
    '{8'hFF,               1'b1, 1'b0, NoRes},
    '{"1",                 1'b1, 1'b1, '{1'b1, "1", cfls_pkg::V_NONE}},
    '{cfls_pkg::CH_DOT,    1'b0, 1'b0, NoRes},
    '{"5",                 1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_UP_E,   1'b1, 1'b1, '{1'b1, cfls_pkg::CH_UP_E, cfls_pkg::V_ERROR}},
    '{cfls_pkg::CH_SLASH,  1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_SLASH,  1'b0, 1'b0, NoRes},
    '{8'hFF,               1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_LF,     1'b0, 1'b0, NoRes},
    '{"2",                 1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_LO_E,   1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_MINUS,  1'b0, 1'b0, NoRes},
    '{"3",                 1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_UP_L,   1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_DQUOTE, 1'b1, 1'b1, '{1'b0, 8'h00, cfls_pkg::V_LDOUBLE}},
    '{cfls_pkg::CH_BSLASH, 1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_DQUOTE, 1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_DQUOTE, 1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_SLASH,  1'b0, 1'b0, NoRes},
    '{" ",                 1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_SLASH,  1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_STAR,   1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_STAR,   1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_STAR,   1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_SLASH,  1'b0, 1'b0, NoRes},
    '{cfls_pkg::CH_DOT,    1'b0, 1'b0, NoRes},
    '{"x",                 1'b1, 1'b1, '{1'b1, "x", cfls_pkg::V_ERROR}}
  };

  c_float_literal_scanner_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .echo_valid (echo_valid),
    .echo_char  (echo_char),
    .verdict    (verdict)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic is_letter(input cfls_pkg::byte_t c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == cfls_pkg::CH_UNDER;
  endfunction

  function automatic logic is_digit(input cfls_pkg::byte_t c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic cfls_pkg::lex_state_t after_literal(input cfls_pkg::byte_t c);
    if (c == cfls_pkg::CH_DQUOTE) return cfls_pkg::ST_STR;
    if (c == cfls_pkg::CH_SQUOTE) return cfls_pkg::ST_CHR;
    if (c == cfls_pkg::CH_SLASH) return cfls_pkg::ST_SLASH;
    if (is_letter(c)) return cfls_pkg::ST_IDENT;
    return cfls_pkg::ST_NORMAL;
  endfunction

  // one lexer step: next state, whether a result comes out, and its fields
  function automatic void lex_step(input cfls_pkg::lex_state_t s, input cfls_pkg::byte_t c,
                                   output cfls_pkg::lex_state_t ns, output logic has,
                                   output logic ev, output cfls_pkg::verdict_t vd);
    ns = s;
    ev = 1'b0;
    vd = cfls_pkg::V_NONE;
    case (s)
      cfls_pkg::ST_STR: begin
        if (c == cfls_pkg::CH_BSLASH) ns = cfls_pkg::ST_STR_ESC;
        else if (c == cfls_pkg::CH_DQUOTE) ns = cfls_pkg::ST_NORMAL;
      end
      cfls_pkg::ST_CHR: begin
        if (c == cfls_pkg::CH_BSLASH) ns = cfls_pkg::ST_CHR_ESC;
        else if (c == cfls_pkg::CH_SQUOTE) ns = cfls_pkg::ST_NORMAL;
      end
      cfls_pkg::ST_STR_ESC: ns = cfls_pkg::ST_STR;
      cfls_pkg::ST_CHR_ESC: ns = cfls_pkg::ST_CHR;
      cfls_pkg::ST_MLCOM: if (c == cfls_pkg::CH_STAR) ns = cfls_pkg::ST_STAR;
      cfls_pkg::ST_SLCOM: begin
        if (c == cfls_pkg::CH_LF || c == cfls_pkg::CH_CR) ns = cfls_pkg::ST_NORMAL;
      end
      cfls_pkg::ST_STAR: begin
        if (c == cfls_pkg::CH_SLASH) ns = cfls_pkg::ST_NORMAL;
        else if (c != cfls_pkg::CH_STAR) ns = cfls_pkg::ST_MLCOM;
      end
      cfls_pkg::ST_IDENT: begin
        if (c == cfls_pkg::CH_SLASH) ns = cfls_pkg::ST_SLASH;
        else if (!is_letter(c) && !is_digit(c)) ns = cfls_pkg::ST_NORMAL;
      end
      cfls_pkg::ST_INT: begin
        ev = 1'b1;
        if (c == cfls_pkg::CH_DOT) ns = cfls_pkg::ST_FRAC;
        else if (c == cfls_pkg::CH_LO_E) ns = cfls_pkg::ST_EXP_MARK;
        else if (!is_digit(c)) begin
          ns = after_literal(c);
          vd = cfls_pkg::V_ERROR;
          ev = !(c == cfls_pkg::CH_DQUOTE || c == cfls_pkg::CH_SQUOTE ||
                 c == cfls_pkg::CH_SLASH);
        end
      end
      cfls_pkg::ST_DOT: begin
        ev = 1'b1;
        if (is_digit(c)) ns = cfls_pkg::ST_FRAC;
        else begin
          ns = after_literal(c);
          vd = cfls_pkg::V_ERROR;
        end
      end
      cfls_pkg::ST_FRAC, cfls_pkg::ST_EXP: begin
        ev = 1'b1;
        if (is_digit(c)) ns = s;
        else if (c == cfls_pkg::CH_DOT && s == cfls_pkg::ST_FRAC) begin
          ns = cfls_pkg::ST_IDENT;
          vd = cfls_pkg::V_ERROR;
        end else if (c == cfls_pkg::CH_UP_L || c == cfls_pkg::CH_LO_L) ns = cfls_pkg::ST_LONG;
        else if (c == cfls_pkg::CH_UP_F || c == cfls_pkg::CH_LO_F) ns = cfls_pkg::ST_FLOAT;
        else if (c == cfls_pkg::CH_LO_E && s == cfls_pkg::ST_FRAC) ns = cfls_pkg::ST_EXP_MARK;
        else if (is_letter(c)) begin
          ns = cfls_pkg::ST_IDENT;
          vd = cfls_pkg::V_ERROR;
        end else begin
          ns = after_literal(c);
          ev = 1'b0;
          vd = cfls_pkg::V_DOUBLE;
        end
      end
      cfls_pkg::ST_EXP_MARK, cfls_pkg::ST_EXP_SIGN: begin
        ev = 1'b1;
        if ((c == cfls_pkg::CH_PLUS || c == cfls_pkg::CH_MINUS) &&
            s == cfls_pkg::ST_EXP_MARK) ns = cfls_pkg::ST_EXP_SIGN;
        else if (is_digit(c)) ns = cfls_pkg::ST_EXP;
        else begin
          ns = after_literal(c);
          vd = cfls_pkg::V_ERROR;
        end
      end
      cfls_pkg::ST_LONG, cfls_pkg::ST_FLOAT: begin
        if (is_digit(c) || is_letter(c)) begin
          ns = cfls_pkg::ST_IDENT;
          ev = 1'b1;
          vd = cfls_pkg::V_ERROR;
        end else begin
          vd = (s == cfls_pkg::ST_LONG) ? cfls_pkg::V_LDOUBLE : cfls_pkg::V_FLOAT;
          ns = after_literal(c);
        end
      end
      default: begin
        // normal, lone slash, and any unused code
        if (c == cfls_pkg::CH_SQUOTE) ns = cfls_pkg::ST_CHR;
        else if (c == cfls_pkg::CH_DQUOTE) ns = cfls_pkg::ST_STR;
        else if (c == cfls_pkg::CH_DOT) begin
          ns = cfls_pkg::ST_DOT;
          ev = 1'b1;
        end else if (c == cfls_pkg::CH_SLASH) begin
          ns = (s == cfls_pkg::ST_SLASH) ? cfls_pkg::ST_SLCOM : cfls_pkg::ST_SLASH;
        end else if (c == cfls_pkg::CH_STAR && s == cfls_pkg::ST_SLASH) ns = cfls_pkg::ST_MLCOM;
        else if (is_letter(c)) ns = cfls_pkg::ST_IDENT;
        else if (is_digit(c)) begin
          ns = cfls_pkg::ST_INT;
          ev = 1'b1;
        end else ns = cfls_pkg::ST_NORMAL;
      end
    endcase
    has = ev || (vd != cfls_pkg::V_NONE);
  endfunction

  function automatic cfls_pkg::byte_t pick(input string s);
    return cfls_pkg::byte_t'(s[$urandom_range(0, s.len() - 1)]);
  endfunction

  // offers one byte, waits for its transfer, then maybe opens a gap
  task automatic send_row(input src_row_t r);
    int gap;
    live_items++;
    in_byte = r.ch;
    cur_row = r;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(0, 40);
    end
  endtask

  task automatic put(input cfls_pkg::byte_t c);
    send_row('{c, 1'b0, 1'b0, NoRes});
  endtask

  task automatic put_digits(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) put(pick(Digits));
  endtask

  // one random token of C-like text; most are well formed, some are noise
  task automatic emit_token();
    int              kind;
    logic            lead;
    cfls_pkg::byte_t q;
    kind = $urandom_range(0, 11);
    case (kind)
      0, 1, 2: begin
        lead = ($urandom_range(0, 4) != 0);
        if (lead) put_digits(1, 4);
        if (!lead || $urandom_range(0, 1) == 1) begin
          put(cfls_pkg::CH_DOT);
          put_digits(lead ? 0 : 1, 3);
        end
        if ($urandom_range(0, 2) == 0) begin
          put(cfls_pkg::CH_LO_E);
          if ($urandom_range(0, 1) == 1) put(pick("+-"));
          put_digits(1, 3);
        end
        if ($urandom_range(0, 2) == 0) put(pick("LlFf"));
        put(pick(Terms));
      end
      3: begin
        repeat ($urandom_range(1, 6)) put(pick("0123456789.eE+-LlFfx_"));
        put(pick(Terms));
      end
      4, 5: begin
        q = (kind == 4) ? cfls_pkg::CH_DQUOTE : cfls_pkg::CH_SQUOTE;
        put(q);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 4) == 0) begin
            put(cfls_pkg::CH_BSLASH);
            put(cfls_pkg::byte_t'($urandom_range(0, 255)));
          end else begin
            put(pick("ab 1.e*/x"));
          end
        end
        put(q);
      end
      6: begin
        put(cfls_pkg::CH_SLASH);
        put(cfls_pkg::CH_SLASH);
        repeat ($urandom_range(0, 8)) put(pick("ab 1.e*/\"'\\"));
        put(pick("\n\r"));
      end
      7: begin
        put(cfls_pkg::CH_SLASH);
        put(cfls_pkg::CH_STAR);
        repeat ($urandom_range(0, 8)) put(pick("ab 1.e**/\"x"));
        put(cfls_pkg::CH_STAR);
        put(cfls_pkg::CH_SLASH);
      end
      8: begin
        put(pick(Letters));
        repeat ($urandom_range(0, 5)) put(pick(Alnum));
        put(pick(Terms));
      end
      9: put(pick(" \t\n;+-()=/"));
      default: repeat ($urandom_range(1, 4)) put(cfls_pkg::byte_t'($urandom_range(0, 255)));
    endcase
  endtask

  // scoreboard: retire results first, then predict the byte taken at this edge
  always @(posedge clk) begin : scoreboard
    lit_result_t          got, want;
    cfls_pkg::lex_state_t nxt;
    logic                 has, ev;
    cfls_pkg::verdict_t   vd;
    if (rst) begin
      scan_state = cfls_pkg::ST_NORMAL;
    end else begin
      if (out_valid && out_ready) begin
        got = '{echo_valid, echo_char, verdict};
        if (exp_lits.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result: echo=%0b char=%02h verdict=%0d",
                     got.echo, got.ch, got.vd);
        end else begin
          want = exp_lits.pop_front();
          if (got.echo != want.echo || got.ch != want.ch || got.vd != want.vd) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: expected echo=%0b char=%02h verdict=%0d",
                       want.echo, want.ch, want.vd,
                       ", got echo=%0b char=%02h verdict=%0d",
                       got.echo, got.ch, got.vd);
          end
        end
      end
      if (in_valid && in_ready) begin
        lex_step(scan_state, in_byte, nxt, has, ev, vd);
        scan_state = nxt;
        if (cur_row.typed) begin
          if (cur_row.has) exp_lits.push_back(cur_row.res);
        end else if (has) begin
          exp_lits.push_back('{ev, ev ? in_byte : 8'h00, vd});
        end
      end
    end
  end

  // receiver: stall pattern changes per stretch; one long hold-off on request
  initial begin : receiver
    int mode, len;
    out_ready = 1'b1;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (400) begin
          @(negedge clk);
          out_ready = 1'b0;
        end
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(10, 150);
        repeat (len) begin
          @(negedge clk);
          case (mode)
            0: out_ready = 1'b1;
            1: out_ready = ($urandom_range(0, 3) != 0);
            2: out_ready = ($urandom_range(0, 3) == 0);
            default: out_ready = $urandom_range(0, 1);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int tokens;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    cur_row = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    foreach (directed_text[i]) send_row(directed_text[i]);

    tokens = 0;
    while (live_items < 1250) begin
      emit_token();
      tokens++;
      if (tokens == 60) hold_req = 1'b1;
      if (tokens == 120) begin
        // let every pending result drain before going on
        in_valid = 1'b0;
        while (exp_lits.size() != 0) @(negedge clk);
      end
    end
    // stream ends inside a literal, so no verdict may follow
    put(cfls_pkg::CH_DOT);
    put("4");
    in_valid = 1'b0;

    while (exp_lits.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (exp_lits.size() != 0) begin
      fail_cnt++;
      $display("%0d expected results never arrived", exp_lits.size());
    end
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== c_float_literal_scanner_core.f =====
sv/cfls_pkg.sv
sv/cfls_next.sv
sv/c_float_literal_scanner_core.sv
tb/tb_c_float_literal_scanner_core.sv
